### hw/rtl/eltf_pkg.sv
`timescale 1ns / 1ps
package eltf_pkg;

  localparam int unsigned AngW = 16;
  localparam int unsigned ForceW = 24;
  localparam int unsigned LinkW = 16;
  localparam int unsigned TorqueW = 32;
  localparam int unsigned CordW = 34;
  localparam int unsigned TabLen = 24;
  localparam int unsigned MulLat = 7;

  localparam logic signed [CordW-1:0] Q30Pi = 34'sd3373259426;
  localparam logic signed [CordW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [CordW-1:0] CordicK = 34'sd652032874;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic flip;
  } cord_t;

  typedef struct packed {
    logic signed [ForceW-1:0] force_v;
    logic [LinkW-1:0] link;
  } side_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CordW-1:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = $signed(34'd1) <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [CordW-1:0] mul30(input logic signed [CordW-1:0] a,
                                                    input logic signed [CordW-1:0] b);
    logic signed [2*CordW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[CordW+29:30];
  endfunction

endpackage

### hw/rtl/eltf_cordic_cell.sv
`timescale 1ns / 1ps
module eltf_cordic_cell
  import eltf_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic  clk_i,
  input  cord_t in_i,
  input  logic  en_i,
  output cord_t out_o
);

  cord_t out_q, out_d;
  localparam logic [4:0] Sh = 5'(Idx);

  always_comb begin
    out_d = in_i;
    if (!in_i.z[CordW-1]) begin
      out_d.x = in_i.x - (in_i.y >>> Sh);
      out_d.y = in_i.y + (in_i.x >>> Sh);
      out_d.z = in_i.z - atan_q30(Sh);
    end else begin
      out_d.x = in_i.x + (in_i.y >>> Sh);
      out_d.y = in_i.y - (in_i.x >>> Sh);
      out_d.z = in_i.z + atan_q30(Sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

### hw/rtl/eltf_cordic_chain.sv
`timescale 1ns / 1ps
module eltf_cordic_chain
  import eltf_pkg::*;
#(
  parameter int unsigned Stages = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] ang_i,
  output logic signed [CordW-1:0] sin_o,
  output logic signed [CordW-1:0] cos_o
);

  cord_t link [Stages+1];
  logic signed [CordW-1:0] z0;

  always_comb begin
    z0 = CordW'(ang_i) <<< 17;
    link[0].x = CordicK;
    link[0].y = '0;
    link[0].flip = 1'b0;
    link[0].z = z0;
    if (z0 > Q30HalfPi) begin
      link[0].z = z0 - Q30Pi;
      link[0].flip = 1'b1;
    end else if (z0 < -Q30HalfPi) begin
      link[0].z = z0 + Q30Pi;
      link[0].flip = 1'b1;
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    eltf_cordic_cell #(.Idx(g)) u_cell (
      .clk_i(clk_i), .in_i(link[g]), .en_i(en_i), .out_o(link[g+1])
    );
  end

  assign sin_o = link[Stages].flip ? -link[Stages].y : link[Stages].y;
  assign cos_o = link[Stages].flip ? -link[Stages].x : link[Stages].x;

endmodule

### hw/rtl/eccentric_leg_torque_from_force_core.sv
`timescale 1ns / 1ps
// Channel   | Dir | tdata fields (low first)                         | tuser
// s_axis    | in  | leg_force, joint, steer, roll, pitch (88 bits)   | -
// m_axis    | out | joint_torque (32 bits)                           | torque_clipped
// One beat is accepted per cycle while the output beat is not held; data passes
// through the CORDIC cell chain followed by seven registered multiply steps.
// The whole pipeline advances together and halts when the output beat is held.
// Reset clears valid flags and restores link_length to 3277.
module eccentric_leg_torque_from_force_core
  import eltf_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // leg_force, joint, steer, roll, pitch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // joint_torque
  output logic        m_axis_tuser   // torque_clipped
);

  localparam int unsigned Depth = CORDIC_STAGES + MulLat;

  logic [LinkW-1:0] link_q;
  logic [Depth-1:0] vld_q;
  logic en;
  side_t side_q [CORDIC_STAGES];
  logic signed [CordW-1:0] sn [4];
  logic signed [CordW-1:0] cs [4];

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= 16'd3277;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) link_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  for (genvar a = 0; a < 4; a++) begin : g_ang
    eltf_cordic_chain #(.Stages(CORDIC_STAGES)) u_chain (
      .clk_i(clk_i), .en_i(en), .ang_i(s_axis_tdata[24+16*a +: 16]),
      .sin_o(sn[a]), .cos_o(cs[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{force_v: s_axis_tdata[23:0], link: link_q};
      for (int i = 1; i < CORDIC_STAGES; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Multiply steps: angle 0 joint, 1 steer, 2 roll, 3 pitch.
  logic signed [CordW-1:0] r31_q, r32_q, r33_q, sq1_q, cq1_q, ss1_q, cs1_q;
  logic signed [CordW-1:0] p1_q, p2_q, r33b_q, sq2_q, cq2_q;
  logic signed [CordW-1:0] a_q, r33c_q, sq3_q, cq3_q;
  logic signed [CordW-1:0] t1_q, t2_q, ju_q;
  logic signed [CordW-1:0] jz_q;
  logic signed [ForceW-1:0] f_q [MulLat-1];
  logic signed [CordW-1:0] tor_q;
  logic signed [CordW+LinkW:0] jl;
  logic signed [CordW+ForceW-1:0] tf;
  logic signed [CordW-1:0] tt;
  logic [LinkW-1:0] l1_q, l2_q, l3_q;
  logic [LinkW-1:0] l4_q, l5_q;

  assign jl = ju_q * $signed({1'b0, l5_q}) + (51'sd1 <<< 15);
  assign tf = jz_q * f_q[MulLat-2] + (58'sd1 <<< 29);
  assign tt = CordW'($signed(tf[CordW+ForceW-1:30]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      r31_q <= -sn[3];
      r32_q <= mul30(sn[2], cs[3]);
      r33_q <= mul30(cs[2], cs[3]);
      sq1_q <= sn[0]; cq1_q <= cs[0]; ss1_q <= sn[1]; cs1_q <= cs[1];
      f_q[0] <= side_q[CORDIC_STAGES-1].force_v;
      l1_q <= side_q[CORDIC_STAGES-1].link;
      p1_q <= mul30(r31_q, cs1_q);
      p2_q <= mul30(r32_q, ss1_q);
      r33b_q <= r33_q; sq2_q <= sq1_q; cq2_q <= cq1_q; l2_q <= l1_q;
      a_q <= p1_q + p2_q;
      r33c_q <= r33b_q; sq3_q <= sq2_q; cq3_q <= cq2_q; l3_q <= l2_q;
      t1_q <= mul30(a_q, cq3_q);
      t2_q <= mul30(r33c_q, sq3_q);
      ju_q <= t1_q + t2_q;
      jz_q <= jl[CordW+15:16];
      tor_q <= tt;
      for (int i = 1; i < MulLat - 1; i++) f_q[i] <= f_q[i-1];
    end
  end

  // Pipeline: l3_q is aligned with a_q; realign for ju_q.
  always_ff @(posedge clk_i) begin
    if (en) begin
      l4_q <= l3_q;
      l5_q <= l4_q;
    end
  end

  // A zero force gives a zero product, so no separate zero path is needed.
  assign m_axis_tdata = (tor_q > 34'sd2147483647) ? 32'h7fffffff :
                        (tor_q < -34'sd2147483648) ? 32'h80000000 : tor_q[31:0];
  assign m_axis_tuser = (tor_q > 34'sd2147483647) || (tor_q < -34'sd2147483648);

endmodule

### hw/rtl/eltf_checker.sv
`timescale 1ns / 1ps
module eltf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is halted");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 32'h7fffffff || m_axis_tdata == 32'h80000000))
    else $error("clip flag without limit value");

endmodule

bind eccentric_leg_torque_from_force_core eltf_checker u_eltf_checker (.*);
